/* rtl/elimination_tree_builder_core_macros.svh */
// Assertion helpers for the elimination tree builder.
// Every check samples on the rising edge of clock and is disabled while reset is high.
`ifndef ELIMINATION_TREE_BUILDER_CORE_MACROS_SVH
`define ELIMINATION_TREE_BUILDER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ETB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ETB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/etb_pkg.sv */
`timescale 1ns / 1ps

package etb_pkg;

   localparam int NODE_W    = 10;
   localparam int MAX_NODES = 2 ** NODE_W;
   localparam int EPOCH_W   = 8;
   localparam int TDATA_W   = ((2 * NODE_W + 7) / 8) * 8;
   localparam int TPAD_W    = TDATA_W - 2 * NODE_W;

   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};
   localparam logic [EPOCH_W-1:0] EPOCH_STALE = '0;

   typedef logic [NODE_W-1:0]  node_type;
   typedef logic [EPOCH_W-1:0] epoch_type;

   // Link memory word: the epoch tag marks the link valid for the current matrix.
   typedef struct packed {
      epoch_type epoch;
      node_type  link;
   } link_entry_type;

   typedef struct packed {
      logic           en;
      logic           we;
      node_type       addr;
      link_entry_type wdata;
   } ram_req_type;

   typedef struct packed {
      node_type row;
      node_type col;
      logic     new_matrix;
   } req_item_type;

   typedef struct packed {
      logic     valid;
      node_type node;
      node_type parent;
   } emit_type;

endpackage

/* rtl/elimination_tree_builder_core.sv */
`timescale 1ns / 1ps
// Channel | Direction | Beat contents (low bit first)
// req_    | in        | tdata: row[9:0], col[19:10], zero pad; tuser: new_matrix
// rsp_    | out       | tdata: node[9:0], parent[19:10], zero pad
//
// Walk: each node that an entry's walk visits on the single-port link memory is
//   read, then evaluated and written back; an entry that hands over a result also
//   passes through an emit state, and an entry at or below the diagonal is dropped
//   after the read of its row.
// Reset: synchronous; afterwards a clearing pass stamps every link stale while
//   req_tready stays low. The same pass runs once when new_matrix arrives with
//   the 8-bit matrix tag at its last value (every 255th matrix).
// Stalls: a result waits in the output register; the next entry is taken meanwhile,
//   and its walk holds only when it has a result of its own to hand over.

module elimination_tree_builder_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [etb_pkg::TDATA_W-1:0]  req_tdata,   // row, col, zero pad
   input  logic                         req_tuser,   // new_matrix
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [etb_pkg::TDATA_W-1:0]  rsp_tdata    // node, parent, zero pad
);
   import etb_pkg::*;

   req_item_type   req_item;
   emit_type       emit;
   logic           emit_ready;
   ram_req_type    ram_req;
   link_entry_type ram_rd_data;

   logic     rsp_valid_ff, rsp_valid_in;
   node_type rsp_node_ff, rsp_node_in;
   node_type rsp_parent_ff, rsp_parent_in;

   // Unpack the request beat.
   assign req_item.row        = req_tdata[NODE_W-1:0];
   assign req_item.col        = req_tdata[2*NODE_W-1:NODE_W];
   assign req_item.new_matrix = req_tuser;

   etb_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_item    (req_item),
      .emit        (emit),
      .emit_ready  (emit_ready),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data)
   );

   etb_link_ram u_link_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

   // Output register: free when empty or being drained this cycle.
   assign emit_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_parent_in = rsp_parent_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      // Load a fresh result; this wins over the drain above.
      if (emit.valid && emit_ready) begin
         rsp_valid_in  = 1'b1;
         rsp_node_in   = emit.node;
         rsp_parent_in = emit.parent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_node_ff   <= rsp_node_in;
      rsp_parent_ff <= rsp_parent_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{TPAD_W{1'b0}}, rsp_parent_ff, rsp_node_ff};

endmodule

/* rtl/etb_link_ram.sv */
`timescale 1ns / 1ps

module etb_link_ram (
   input  logic                    clock,
   input  etb_pkg::ram_req_type    ram_req,
   output etb_pkg::link_entry_type rd_data
);
   import etb_pkg::*;

   link_entry_type mem [MAX_NODES];
   link_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.en && ram_req.we) begin
         mem[ram_req.addr] <= ram_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.en && !ram_req.we) begin
         rd_data_ff <= mem[ram_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/etb_walker.sv */
`timescale 1ns / 1ps

module etb_walker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  etb_pkg::req_item_type   req_item,
   output etb_pkg::emit_type       emit,
   input  logic                    emit_ready,
   output etb_pkg::ram_req_type    ram_req,
   input  etb_pkg::link_entry_type ram_rd_data
);
   import etb_pkg::*;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   node_type  cur_ff, cur_in;
   node_type  col_ff, col_in;
   epoch_type epoch_ff, epoch_in;
   node_type  sweep_ff, sweep_in;
   logic      pending_ff, pending_in;
   logic      hit;

   assign hit = (ram_rd_data.epoch == epoch_ff);

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      col_in     = col_ff;
      epoch_in   = epoch_ff;
      sweep_in   = sweep_ff;
      pending_in = pending_ff;
      ram_req    = '0;
      unique case (state_ff)
         ST_SWEEP: begin
            // Stamp every entry stale, one per cycle.
            ram_req.en    = 1'b1;
            ram_req.we    = 1'b1;
            ram_req.addr  = sweep_ff;
            ram_req.wdata = '{epoch: EPOCH_STALE, link: '0};
            sweep_in      = sweep_ff + 1'b1;
            if (sweep_ff == node_type'(MAX_NODES - 1)) begin
               pending_in = 1'b0;
               state_in   = pending_ff ? ST_READ : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cur_in = req_item.row;
               col_in = req_item.col;
               if (req_item.new_matrix && (epoch_ff == EPOCH_LAST)) begin
                  // Tags are about to wrap: sweep first, then walk.
                  epoch_in   = EPOCH_FIRST;
                  sweep_in   = '0;
                  pending_in = 1'b1;
                  state_in   = ST_SWEEP;
               end else begin
                  if (req_item.new_matrix) begin
                     epoch_in = epoch_ff + 1'b1;
                  end
                  ram_req.en   = 1'b1;
                  ram_req.addr = req_item.row;
                  state_in     = ST_EVAL;
               end
            end
         end
         ST_READ: begin
            ram_req.en   = 1'b1;
            ram_req.addr = cur_ff;
            state_in     = ST_EVAL;
         end
         ST_EVAL: begin
            priority if (cur_ff >= col_ff) begin
               // Lower or diagonal entry: drop it.
               state_in = ST_IDLE;
            end else begin
               ram_req.en    = 1'b1;
               ram_req.we    = 1'b1;
               ram_req.addr  = cur_ff;
               ram_req.wdata = '{epoch: epoch_ff, link: col_ff};
               priority if (!hit) begin
                  state_in = ST_EMIT;
               end else if (ram_rd_data.link >= col_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  cur_in   = ram_rd_data.link;
                  state_in = ST_READ;
               end
            end
         end
         ST_EMIT: begin
            if (emit_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_SWEEP;
         epoch_ff   <= EPOCH_FIRST;
         sweep_ff   <= '0;
         pending_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         epoch_ff   <= epoch_in;
         sweep_ff   <= sweep_in;
         pending_ff <= pending_in;
      end
      cur_ff <= cur_in;
      col_ff <= col_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign emit.valid  = (state_ff == ST_EMIT);
   assign emit.node   = cur_ff;
   assign emit.parent = col_ff;

endmodule

/* rtl/etb_checker.sv */
`timescale 1ns / 1ps
`include "elimination_tree_builder_core_macros.svh"

module etb_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [etb_pkg::TDATA_W-1:0] rsp_tdata
);
   import etb_pkg::*;

   logic              req_beat;
   logic              rsp_stall;
   node_type          rsp_node;
   node_type          rsp_parent;
   logic [TPAD_W-1:0] rsp_pad;

   assign req_beat   = req_tvalid && req_tready;
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign rsp_node   = rsp_tdata[NODE_W-1:0];
   assign rsp_parent = rsp_tdata[2*NODE_W-1:NODE_W];
   assign rsp_pad    = rsp_tdata[TDATA_W-1:2*NODE_W];

   // Each accepted entry keeps the walker busy in the next cycle.
   `ETB_ASSERT_NEXT(a_busy_after_beat, req_beat, !req_tready, "req_tready high after a beat")

   // Tree links always point to a larger column.
   `ETB_ASSERT_NOW(a_parent_above_node, rsp_tvalid, rsp_parent > rsp_node, "parent not above node")

   // Pad bits of the result beat stay zero.
   `ETB_ASSERT_NOW(a_pad_zero, rsp_tvalid, rsp_pad == '0, "nonzero pad in rsp_tdata")

   // A stalled result holds its valid and data.
   `ETB_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "stalled beat changed")

endmodule

bind elimination_tree_builder_core etb_checker u_etb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
